// ===== rtl/assert_macros.svh =====
// Assertion macros used by the frame parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/slxfp_pkg.sv =====
// Types and constants of the sync/length/XOR frame parser.
`timescale 1ns / 1ps

package slxfp_pkg;

  // Parser phases, one-hot.
  typedef enum logic [6:0] {
    PH_SYNC1  = 7'b000_0001,
    PH_SYNC2  = 7'b000_0010,
    PH_ID     = 7'b000_0100,
    PH_LEN    = 7'b000_1000,
    PH_DATA   = 7'b001_0000,
    PH_CSUM   = 7'b010_0000,
    PH_REPLAY = 7'b100_0000
  } phase_e;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SYNC_FIRST   = 3'd0;
  localparam logic [2:0] REG_SYNC_SECOND  = 3'd1;
  localparam logic [2:0] REG_ACCEPTED_ID  = 3'd2;
  localparam logic [2:0] REG_EXPECTED_LEN = 3'd3;
  localparam logic [2:0] REG_ROBOT_TAG    = 3'd4;

  // Register reset values.
  localparam logic [7:0] RST_SYNC_FIRST   = 8'd170;
  localparam logic [7:0] RST_SYNC_SECOND  = 8'd85;
  localparam logic [7:0] RST_ACCEPTED_ID  = 8'd1;
  localparam logic [6:0] RST_EXPECTED_LEN = 7'd20;
  localparam logic [7:0] RST_ROBOT_TAG    = 8'd0;

endpackage

// ===== rtl/slxfp_in_if.sv =====
// Received-byte channel: one serial byte and its timestamp per transaction.
`timescale 1ns / 1ps

interface slxfp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] time_ms;

  modport source (output valid, rx_byte, time_ms, input ready);
  modport sink   (input valid, rx_byte, time_ms, output ready);
endinterface

// ===== rtl/slxfp_out_if.sv =====
// Payload channel: one replayed payload byte of an accepted frame per transaction.
`timescale 1ns / 1ps

interface slxfp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [5:0]  byte_index;
  logic [31:0] stamp_ms;
  logic [7:0]  robot_tag;
  logic        last_byte;

  modport source (output valid, data_byte, byte_index, stamp_ms, robot_tag, last_byte,
                  input ready);
  modport sink   (input valid, data_byte, byte_index, stamp_ms, robot_tag, last_byte,
                  output ready);
endinterface

// ===== rtl/sync_length_xor_frame_parser.sv =====
// Frame parser: two sync bytes, id, length, payload, XOR checksum; replays accepted payloads.
//
// Usage:
//   rx_i takes one received byte with its millisecond time per transaction. While
//   parsing, a byte is taken every cycle. After a checksum byte that matches, with
//   the configured id and length, the payload held in the on-chip payload memory is
//   replayed on tx_o as L transactions, one per payload byte, each carrying the
//   checksum byte's time, the configured robot tag, its index and a last flag.
//   After the checksum transaction, the first payload byte passes the memory read register
//   and the output register before it is valid on tx_o. Replay issues one read of the
//   single-port payload memory per cycle unless tx_o stalls, and rx_i is held off while
//   the reads are issued; rx_i.ready returns as soon as the last read is issued. A stall
//   on tx_o backs up through the output register and the memory read register and
//   pauses the reads; nothing is dropped. Registers are written over the APB-style port
//   at byte address 4*i; the user must write them only while the block is idle, as the
//   block itself does not enforce it. Reset returns the parser to hunting for the first
//   sync byte and restores the register defaults; the payload memory is not cleared, as
//   only bytes of the current frame are ever read back.
`timescale 1ns / 1ps

module sync_length_xor_frame_parser
  import slxfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slxfp_in_if.sink    rx_i,
  slxfp_out_if.source tx_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0]  MaxLen8 = 8'(MAX_PAYLOAD);
  localparam logic [6:0]  MaxLen7 = 7'(MAX_PAYLOAD);

  // Configuration registers
  logic [7:0] sync_first_q, sync_second_q, accepted_id_q, robot_tag_q;
  logic [6:0] expected_len_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q   <= RST_SYNC_FIRST;
      sync_second_q  <= RST_SYNC_SECOND;
      accepted_id_q  <= RST_ACCEPTED_ID;
      expected_len_q <= RST_EXPECTED_LEN;
      robot_tag_q    <= RST_ROBOT_TAG;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_SYNC_FIRST:   sync_first_q   <= pwdata[7:0];
        REG_SYNC_SECOND:  sync_second_q  <= pwdata[7:0];
        REG_ACCEPTED_ID:  accepted_id_q  <= pwdata[7:0];
        REG_EXPECTED_LEN: expected_len_q <= pwdata[6:0];
        REG_ROBOT_TAG:    robot_tag_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SYNC_FIRST:   prdata = {24'd0, sync_first_q};
      REG_SYNC_SECOND:  prdata = {24'd0, sync_second_q};
      REG_ACCEPTED_ID:  prdata = {24'd0, accepted_id_q};
      REG_EXPECTED_LEN: prdata = {25'd0, expected_len_q};
      REG_ROBOT_TAG:    prdata = {24'd0, robot_tag_q};
      default:          prdata = '0;
    endcase
  end

  // Parser state
  phase_e      phase_q, phase_d;
  logic [7:0]  frame_id_q, frame_id_d;
  logic [6:0]  frame_len_q, frame_len_d;
  logic [6:0]  fill_q, fill_d;
  logic [7:0]  xor_q, xor_d;
  logic [6:0]  rd_cnt_q, rd_cnt_d;
  logic [31:0] stamp_q, stamp_d;

  // Replay pipeline: memory read register, then output register
  logic        s1_v_q;
  logic [7:0]  s1_data_q;
  logic [5:0]  s1_idx_q;
  logic        s1_last_q;
  logic [31:0] s1_stamp_q;
  logic        s1_move;
  logic        out_v_q;
  logic [7:0]  out_data_q;
  logic [5:0]  out_idx_q;
  logic [31:0] out_stamp_q;
  logic [7:0]  out_tag_q;
  logic        out_last_q;

  logic        in_fire, tx_fire, do_hunt, mem_we, issue, issue_last;
  logic [7:0]  b;
  logic [6:0]  rd_next;
  logic [7:0]  mem_q [MAX_PAYLOAD];

  assign b        = rx_i.rx_byte;
  assign rx_i.ready = (phase_q != PH_REPLAY);
  assign in_fire  = rx_i.valid && rx_i.ready;
  assign tx_fire  = tx_o.valid && tx_o.ready;
  assign s1_move  = s1_v_q && (!out_v_q || tx_o.ready);
  assign rd_next  = rd_cnt_q + 7'd1;

  always_comb begin
    phase_d     = phase_q;
    frame_id_d  = frame_id_q;
    frame_len_d = frame_len_q;
    fill_d      = fill_q;
    xor_d       = xor_q;
    rd_cnt_d    = rd_cnt_q;
    stamp_d     = stamp_q;
    do_hunt     = 1'b0;
    mem_we      = 1'b0;
    issue       = 1'b0;
    issue_last  = 1'b0;
    case (phase_q)
      PH_SYNC1: begin
        if (in_fire && b == sync_first_q) phase_d = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (in_fire) begin
          if (b == sync_second_q) phase_d = PH_ID;
          else do_hunt = 1'b1;
        end
      end
      PH_ID: begin
        if (in_fire) begin
          frame_id_d = b;
          xor_d      = b;
          phase_d    = PH_LEN;
        end
      end
      PH_LEN: begin
        if (in_fire) begin
          if (b == 8'd0 || b > MaxLen8) begin
            do_hunt = 1'b1;
          end else begin
            frame_len_d = b[6:0];
            xor_d       = xor_q ^ b;
            fill_d      = '0;
            phase_d     = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (in_fire) begin
          mem_we = (fill_q < MaxLen7);
          fill_d = fill_q + 7'd1;
          xor_d  = xor_q ^ b;
          if (fill_d >= frame_len_q) phase_d = PH_CSUM;
        end
      end
      PH_CSUM: begin
        if (in_fire) begin
          if (b == xor_q && frame_id_q == accepted_id_q && frame_len_q == expected_len_q)
          begin
            stamp_d  = rx_i.time_ms;
            rd_cnt_d = '0;
            phase_d  = PH_REPLAY;
          end else begin
            do_hunt = 1'b1;
          end
        end
      end
      PH_REPLAY: begin
        // Advance a read only when the read register is free or moving on.
        if (!s1_v_q || s1_move) begin
          issue      = 1'b1;
          rd_cnt_d   = rd_next;
          issue_last = (rd_next == frame_len_q);
          if (issue_last) do_hunt = 1'b1;
        end
      end
      default: do_hunt = 1'b1;
    endcase
    if (do_hunt) begin
      phase_d     = PH_SYNC1;
      frame_id_d  = '0;
      frame_len_d = '0;
      fill_d      = '0;
      xor_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC1;
      frame_id_q  <= '0;
      frame_len_q <= '0;
      fill_q      <= '0;
      xor_q       <= '0;
      rd_cnt_q    <= '0;
      s1_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      frame_id_q  <= frame_id_d;
      frame_len_q <= frame_len_d;
      fill_q      <= fill_d;
      xor_q       <= xor_d;
      rd_cnt_q    <= rd_cnt_d;
      if (issue) s1_v_q <= 1'b1;
      else if (s1_move) s1_v_q <= 1'b0;
      if (s1_move) out_v_q <= 1'b1;
      else if (tx_fire) out_v_q <= 1'b0;
    end
  end

  // Payload memory: writes happen only while filling, reads only while
  // replaying, so the same entry is never written and read in one cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[fill_q[IdxW-1:0]] <= b;
    if (issue) s1_data_q <= mem_q[rd_cnt_q[IdxW-1:0]];
  end

  // Carry the stamp with each read, as the next frame may update stamp_q
  // before a stalled byte reaches the output register.
  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    if (issue) begin
      s1_idx_q   <= rd_cnt_q[5:0];
      s1_last_q  <= issue_last;
      s1_stamp_q <= stamp_q;
    end
    if (s1_move) begin
      out_data_q  <= s1_data_q;
      out_idx_q   <= s1_idx_q;
      out_last_q  <= s1_last_q;
      out_stamp_q <= s1_stamp_q;
      out_tag_q   <= robot_tag_q;
    end
  end

  assign tx_o.valid      = out_v_q;
  assign tx_o.data_byte  = out_data_q;
  assign tx_o.byte_index = out_idx_q;
  assign tx_o.stamp_ms   = out_stamp_q;
  assign tx_o.robot_tag  = out_tag_q;
  assign tx_o.last_byte  = out_last_q;

`include "assert_macros.svh"

  `ASSERT_CLK(replay_cnt_a, (phase_q == PH_REPLAY) |-> (rd_cnt_q < frame_len_q),
              "replay read counter ran past the frame length")
  `ASSERT_CLK(s1_hold_a, (s1_v_q && !s1_move) |=> (s1_v_q && $stable(s1_data_q)),
              "stalled memory read data was lost")
  `ASSERT_NEVER(mem_rw_a, mem_we && issue,
                "payload memory written and read in the same cycle")

endmodule
